// ----- hdl/cll_pkg.sv -----
// shared types, constants and helpers for the cursor linked list
package cll_pkg;

  // store geometry
  localparam int SLOTS    = 64;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CAPACITY = SLOTS - 2;
  localparam int CNT_W    = $clog2(SLOTS);

  // fixed field widths
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  // width for position against count compares
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [SLOT_W-1:0] FREE_SLOT = '0;
  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(SLOTS - 1);

  // request kinds
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_LENGTH = 2'd2,
    FN_DUMP   = 2'd3
  } func_e;

  // result codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    func_e                    func;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [COUNT_W-1:0]       count;
    logic signed [VAL_W-1:0]  element;
    logic                     element_valid;
    logic                     last;
  } out_t;

  // link held by a slot right after reset
  function automatic logic [SLOT_W-1:0] link_reset(logic [SLOT_W-1:0] slot);
    return (slot == HEAD_SLOT) ? FREE_SLOT : slot + 1'b1;
  endfunction

endpackage

// ----- hdl/cursor_linked_list_core.sv -----
// cursor linked list: request sequencer around the link and value memories
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | to core   | in_valid_i / in_stall_o | in_i  (func, position, value)
//  out     | from core | out_valid_o / out_stall_i | out_o (status, count, element,
//          |           |                        |        element_valid, last)
//
// one request at a time; each link hop is one read of the link memory per cycle
// insert and delete walk the links up to the position, length reads no memory,
// dump sends one element item per cycle while the output is not stalled
// reset is immediate: per-slot valid flops make unwritten links read as i+1
// a stalled output holds the sequencer only where it has an item to hand over
module cursor_linked_list_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cll_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cll_pkg::out_t out_o
);
  import cll_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_INS_J  = 12'b0000_0000_0010,
    S_INS_FR = 12'b0000_0000_0100,
    S_WALK   = 12'b0000_0000_1000,
    S_INS_LK = 12'b0000_0001_0000,
    S_DEL_J  = 12'b0000_0010_0000,
    S_DEL_RD = 12'b0000_0100_0000,
    S_DEL_FR = 12'b0000_1000_0000,
    S_DEL_HD = 12'b0001_0000_0000,
    S_DMP_HD = 12'b0010_0000_0000,
    S_DMP_EL = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  func_e                   op_q, op_d;
  logic [POS_W-1:0]        steps_q, steps_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [SLOT_W-1:0]       k_q, k_d;
  logic [SLOT_W-1:0]       j_q, j_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        dump_n_q, dump_n_d;
  status_e                 status_q, status_d;
  logic [SLOTS-1:0]        lvalid_q;
  logic [SLOT_W-1:0]       rd_slot_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic                    in_accept;
  logic                    out_free;
  logic                    link_we;
  logic [SLOT_W-1:0]       link_waddr;
  logic [SLOT_W-1:0]       link_wdata;
  logic                    val_we;
  logic                    rd_en;
  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       link_ram_rd;
  logic [SLOT_W-1:0]       link_rd;
  logic signed [VAL_W-1:0] value_rd;
  logic                    emit_v;
  out_t                    emit_item;
  logic [CMP_W-1:0]        pos_x;
  logic [CMP_W-1:0]        cnt_x;
  logic                    ins_bad;
  logic                    del_bad;
  logic                    dump_fin;

  // memories
  cll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_ram_rd)
  );

  cll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (j_q),
    .wdata_i (val_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (value_rd)
  );

  // unwritten links read as their reset value
  assign link_rd = lvalid_q[rd_slot_q] ? link_ram_rd : link_reset(rd_slot_q);

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // position checks against the current count
  assign pos_x   = CMP_W'(in_i.position);
  assign cnt_x   = CMP_W'(count_q);
  assign ins_bad = (in_i.position == '0) || (pos_x > cnt_x + 1'b1);
  assign del_bad = (in_i.position == '0) || (pos_x > cnt_x);

  // last element of a dump
  assign dump_fin = (link_rd == FREE_SLOT) || ((CMP_W'(dump_n_q) + 1'b1) >= cnt_x);

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    steps_d    = steps_q;
    val_d      = val_q;
    k_d        = k_q;
    j_d        = j_q;
    count_d    = count_q;
    dump_n_d   = dump_n_q;
    status_d   = status_q;
    link_we    = 1'b0;
    link_waddr = FREE_SLOT;
    link_wdata = FREE_SLOT;
    val_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = FREE_SLOT;
    emit_v     = 1'b0;
    emit_item  = '{status: status_q, count: COUNT_W'(count_q), element: '0,
                   element_valid: 1'b0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d     = in_i.func;
          val_d    = in_i.value;
          steps_d  = in_i.position - 1'b1;
          k_d      = HEAD_SLOT;
          dump_n_d = '0;
          status_d = ST_OK;
          unique case (in_i.func)
            FN_INSERT: begin
              if (ins_bad) begin
                status_d = ST_BAD_POS;
                state_d  = S_EMIT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = FREE_SLOT;
                state_d = S_INS_J;
              end
            end
            FN_DELETE: begin
              if (del_bad) begin
                status_d = ST_BAD_POS;
                state_d  = S_EMIT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = HEAD_SLOT;
                state_d = S_WALK;
              end
            end
            FN_LENGTH: begin
              state_d = S_EMIT;
            end
            FN_DUMP: begin
              rd_en   = 1'b1;
              rd_addr = HEAD_SLOT;
              state_d = S_DMP_HD;
            end
            default: begin
              state_d = S_EMIT;
            end
          endcase
        end
      end

      // first free slot
      S_INS_J: begin
        if ((CMP_W'(count_q) >= CMP_W'(CAPACITY)) || (link_rd == FREE_SLOT) ||
            (link_rd == HEAD_SLOT)) begin
          status_d = ST_FULL;
          state_d  = S_EMIT;
        end else begin
          j_d     = link_rd;
          rd_en   = 1'b1;
          rd_addr = link_rd;
          state_d = S_INS_FR;
        end
      end

      // pop the free slot, store the value, start the walk
      S_INS_FR: begin
        link_we    = 1'b1;
        link_waddr = FREE_SLOT;
        link_wdata = link_rd;
        val_we     = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = HEAD_SLOT;
        state_d    = S_WALK;
      end

      // follow links until the slot before the position
      S_WALK: begin
        if (steps_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
          k_d     = link_rd;
          steps_d = steps_q - 1'b1;
        end else if (op_q == FN_INSERT) begin
          link_we    = 1'b1;
          link_waddr = j_q;
          link_wdata = link_rd;
          state_d    = S_INS_LK;
        end else if ((link_rd == FREE_SLOT) || (link_rd == HEAD_SLOT)) begin
          status_d = ST_BAD_POS;
          state_d  = S_EMIT;
        end else begin
          j_d     = link_rd;
          rd_en   = 1'b1;
          rd_addr = link_rd;
          state_d = S_DEL_J;
        end
      end

      S_INS_LK: begin
        link_we    = 1'b1;
        link_waddr = k_q;
        link_wdata = j_q;
        count_d    = count_q + 1'b1;
        state_d    = S_EMIT;
      end

      // unlink the deleted slot
      S_DEL_J: begin
        link_we    = 1'b1;
        link_waddr = k_q;
        link_wdata = link_rd;
        state_d    = S_DEL_RD;
      end

      S_DEL_RD: begin
        rd_en   = 1'b1;
        rd_addr = FREE_SLOT;
        state_d = S_DEL_FR;
      end

      // push the slot onto the free list
      S_DEL_FR: begin
        link_we    = 1'b1;
        link_waddr = j_q;
        link_wdata = link_rd;
        state_d    = S_DEL_HD;
      end

      S_DEL_HD: begin
        link_we    = 1'b1;
        link_waddr = FREE_SLOT;
        link_wdata = j_q;
        count_d    = count_q - 1'b1;
        state_d    = S_EMIT;
      end

      // first data slot
      S_DMP_HD: begin
        if ((link_rd == FREE_SLOT) || (count_q == '0)) begin
          state_d = S_EMIT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
          state_d = S_DMP_EL;
        end
      end

      // one element item per cycle while the output is not stalled
      S_DMP_EL: begin
        emit_item = '{status: ST_OK, count: COUNT_W'(count_q), element: value_rd,
                      element_valid: 1'b1, last: dump_fin};
        if (out_free) begin
          emit_v   = 1'b1;
          dump_n_d = dump_n_q + 1'b1;
          if (dump_fin) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = link_rd;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          emit_v  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      lvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (link_we) begin
        lvalid_q[link_waddr] <= 1'b1;
      end
      if (emit_v) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    steps_q  <= steps_d;
    val_q    <= val_d;
    k_q      <= k_d;
    j_q      <= j_d;
    dump_n_q <= dump_n_d;
    status_q <= status_d;
    if (rd_en) begin
      rd_slot_q <= rd_addr;
    end
    if (emit_v) begin
      out_q <= emit_item;
    end
  end

  // checks
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_no_rw_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_we && rd_en) |-> (link_waddr != rd_addr))
    else $error("link read and write to one slot in the same cycle");

  a_count_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_INS_LK) && (state_q != S_DEL_HD)) |=> $stable(count_q))
    else $error("count changed outside an insert or delete update");

  a_plain_item_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_v && !emit_item.element_valid) |-> emit_item.last)
    else $error("item without an element not marked last");

endmodule

// ----- hdl/cll_ram.sv -----
// generic single write port ram with registered read
module cll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
